[hdl/clipped_transparent_blit_top_macros.svh]
// assertion macros for the clipped transparent blit block
// used by files that check their own logic; expects clk_i and rst_ni in scope
`ifndef CLIPPED_TRANSPARENT_BLIT_TOP_MACROS_SVH
`define CLIPPED_TRANSPARENT_BLIT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// property held at every clock edge outside reset
`define CTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// same-cycle implication
`define CTB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CTB_ASSERT(lbl, prop, msg)
`define CTB_ASSERT_IMPLY(lbl, ante, cons, msg)
`define CTB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/ctb_pkg.sv]
// shared types and constants for the clipped transparent blit block
// no dependencies
`timescale 1ns / 1ps

package ctb_pkg;

  // widest frame index over the supported screen sizes (64 x 32)
  localparam int MaxAddrW = 11;
  // entries in the queue between front and back
  localparam int QDepth = 2;

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_BLIT  = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  // work for the back end
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic                 in_bounds;
    logic [MaxAddrW-1:0]  addr;
    logic [1:0]           value;
  } cmd_t;

endpackage

[hdl/ctb_front.sv]
// front end: accepts request beats, clips the target and classifies the work
// depends on ctb_pkg
`timescale 1ns / 1ps

module ctb_front #(
  parameter int SCREEN_WIDTH  = 40,
  parameter int SCREEN_HEIGHT = 30
) (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [6:0]  pos_x_i,
  input  logic signed [5:0]  pos_y_i,
  input  logic [5:0]         cell_x_i,
  input  logic [4:0]         cell_y_i,
  input  logic [1:0]         cell_value_i,
  input  logic               blend_transparent_i,
  input  logic               q_full_i,
  input  logic               sweep_busy_i,
  output logic               push_o,
  output ctb_pkg::cmd_t      cmd_o
);

  logic signed [7:0] tx;
  logic signed [6:0] ty;
  logic              on_screen;
  logic [ctb_pkg::MaxAddrW-1:0] index;

  // target position, one bit wider than the operands
  assign tx = $signed({pos_x_i[6], pos_x_i}) + $signed({2'b00, cell_x_i});
  assign ty = $signed({pos_y_i[5], pos_y_i}) + $signed({2'b00, cell_y_i});

  // clip against the screen edges
  assign on_screen = !tx[7] && (tx[6:0] < 7'(SCREEN_WIDTH)) &&
                     !ty[6] && (ty[5:0] < 6'(SCREEN_HEIGHT));

  // row-major index; on screen ty fits 5 bits and tx fits 6
  assign index = ctb_pkg::MaxAddrW'(ty[4:0]) * ctb_pkg::MaxAddrW'(SCREEN_WIDTH) +
                 ctb_pkg::MaxAddrW'(tx[5:0]);

  // hold off while the queue is full or the store is being wiped
  assign in_stall_o = q_full_i || sweep_busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  // classify the request
  always_comb begin
    cmd_o.kind      = ctb_pkg::CMD_NOP;
    cmd_o.in_bounds = 1'b0;
    cmd_o.addr      = index;
    cmd_o.value     = cell_value_i;
    case (req_type_i)
      ctb_pkg::REQ_CLEAR: begin
        cmd_o.kind = ctb_pkg::CMD_CLEAR;
      end
      ctb_pkg::REQ_BLIT: begin
        cmd_o.in_bounds = on_screen;
        if (on_screen && (!blend_transparent_i || cell_value_i != 2'd0)) begin
          cmd_o.kind = ctb_pkg::CMD_WRITE;
        end
      end
      ctb_pkg::REQ_READ: begin
        cmd_o.in_bounds = on_screen;
        if (on_screen) begin
          cmd_o.kind = ctb_pkg::CMD_READ;
        end
      end
      default: begin
        cmd_o.kind = ctb_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

[hdl/ctb_fifo.sv]
// short command queue between front and back ends
// depends on ctb_pkg
`timescale 1ns / 1ps

module ctb_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ctb_pkg::cmd_t  cmd_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output ctb_pkg::cmd_t  cmd_o
);

  localparam int PtrW = (ctb_pkg::QDepth > 1) ? $clog2(ctb_pkg::QDepth) : 1;
  localparam int CntW = $clog2(ctb_pkg::QDepth + 1);

  ctb_pkg::cmd_t   slot_q [ctb_pkg::QDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(ctb_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rptr_q];

  // pointer and fill count updates
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(ctb_pkg::QDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(ctb_pkg::QDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

[hdl/ctb_back.sv]
// back end: frame store, clearing sweep and result register
// depends on ctb_pkg and clipped_transparent_blit_top_macros.svh
`timescale 1ns / 1ps
`include "clipped_transparent_blit_top_macros.svh"

module ctb_back #(
  parameter int SCREEN_WIDTH  = 40,
  parameter int SCREEN_HEIGHT = 30
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  ctb_pkg::cmd_t  q_cmd_i,
  output logic           pop_o,
  output logic           sweep_busy_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           in_bounds_o,
  output logic           written_o,
  output logic [1:0]     read_value_o
);

  localparam int Cells = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AddrW = (Cells > 1) ? $clog2(Cells) : 1;

  logic [1:0]             mem_q [Cells];
  logic [1:0]             rd_data_q;
  logic                   mem_we;
  logic [AddrW-1:0]       mem_waddr;
  logic [1:0]             mem_wdata;
  logic                   mem_re;

  logic                   sweep_q, sweep_d;
  logic [AddrW-1:0]       sweep_cnt_q, sweep_cnt_d;
  logic                   s1_valid_q, s1_valid_d;
  ctb_pkg::cmd_kind_e     s1_kind_q;
  logic                   s1_inb_q;
  logic                   s1_adv;
  logic                   out_valid_q, out_valid_d;
  logic                   out_inb_q;
  logic                   out_wr_q;
  logic [1:0]             out_rd_q;

  // stage handoff
  assign s1_adv = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign pop_o  = q_valid_i && !sweep_q && (!s1_valid_q || s1_adv);

  // single write port: the sweep or a composite beat
  assign mem_we    = sweep_q || (pop_o && q_cmd_i.kind == ctb_pkg::CMD_WRITE);
  assign mem_waddr = sweep_q ? sweep_cnt_q : q_cmd_i.addr[AddrW-1:0];
  assign mem_wdata = sweep_q ? 2'd0 : q_cmd_i.value;
  assign mem_re    = pop_o && q_cmd_i.kind == ctb_pkg::CMD_READ;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[q_cmd_i.addr[AddrW-1:0]];
    end
  end

  // clearing sweep, one cell per cycle
  always_comb begin
    sweep_d     = sweep_q;
    sweep_cnt_d = sweep_cnt_q;
    if (sweep_q) begin
      if (sweep_cnt_q == AddrW'(Cells - 1)) begin
        sweep_d = 1'b0;
      end else begin
        sweep_cnt_d = sweep_cnt_q + 1'b1;
      end
    end else if (pop_o && q_cmd_i.kind == ctb_pkg::CMD_CLEAR) begin
      sweep_d     = 1'b1;
      sweep_cnt_d = '0;
    end
  end

  // valid flags of the two stages
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sweep_q     <= sweep_d;
      sweep_cnt_q <= sweep_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_kind_q <= q_cmd_i.kind;
      s1_inb_q  <= q_cmd_i.in_bounds;
    end
    if (s1_adv) begin
      out_inb_q <= s1_inb_q;
      out_wr_q  <= (s1_kind_q == ctb_pkg::CMD_WRITE);
      out_rd_q  <= (s1_kind_q == ctb_pkg::CMD_READ) ? rd_data_q : 2'd0;
    end
  end

  assign sweep_busy_o = sweep_q;
  assign out_valid_o  = out_valid_q;
  assign in_bounds_o  = out_inb_q;
  assign written_o    = out_wr_q;
  assign read_value_o = out_rd_q;

  // checks
  `CTB_ASSERT_IMPLY(a_no_pop_in_sweep, sweep_q, !pop_o, "queue popped during sweep")
  `CTB_ASSERT_NEXT(a_clear_starts_sweep, pop_o && q_cmd_i.kind == ctb_pkg::CMD_CLEAR,
    sweep_q && sweep_cnt_q == '0, "clear did not start sweep")
  `CTB_ASSERT_IMPLY(a_sweep_in_range, sweep_q, sweep_cnt_q <= AddrW'(Cells - 1),
    "sweep index past the store")
  `CTB_ASSERT_IMPLY(a_held_stage_no_pop, s1_valid_q && !s1_adv, !pop_o,
    "pop while stage held")
  `CTB_ASSERT(a_write_read_apart, !(out_valid_q && out_wr_q && out_rd_q != 2'd0),
    "result both written and read")

endmodule

[hdl/clipped_transparent_blit_top.sv]
// channel    | direction | beat
// in         | input     | one request: clear, composite cell or read cell
// out        | output    | one result: in_bounds, written, read_value
//
// composite and read beats sustain one per cycle unless out_stall_i or a sweep
// holds them off; each result goes through the queue, stage one and the output register.
// a clear walks the frame store one cell per cycle through its single write
// port, with in_stall_o high until the sweep is done.
// after reset the same sweep runs before the first beat is taken.
// a two-beat queue separates request intake from the store side.
// top level of the clipped transparent blit; depends on ctb_pkg, ctb_front,
// ctb_fifo and ctb_back
`timescale 1ns / 1ps

module clipped_transparent_blit_top #(
  parameter int SCREEN_WIDTH  = 40,  // 1 to 64
  parameter int SCREEN_HEIGHT = 30   // 1 to 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [6:0]  pos_x_i,
  input  logic signed [5:0]  pos_y_i,
  input  logic [5:0]         cell_x_i,
  input  logic [4:0]         cell_y_i,
  input  logic [1:0]         cell_value_i,
  input  logic               blend_transparent_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               in_bounds_o,
  output logic               written_o,
  output logic [1:0]         read_value_o
);

  logic          push;
  logic          q_full;
  logic          q_valid;
  logic          pop;
  logic          sweep_busy;
  ctb_pkg::cmd_t front_cmd;
  ctb_pkg::cmd_t back_cmd;

  // request intake and clipping
  ctb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .req_type_i          (req_type_i),
    .pos_x_i             (pos_x_i),
    .pos_y_i             (pos_y_i),
    .cell_x_i            (cell_x_i),
    .cell_y_i            (cell_y_i),
    .cell_value_i        (cell_value_i),
    .blend_transparent_i (blend_transparent_i),
    .q_full_i            (q_full),
    .sweep_busy_i        (sweep_busy),
    .push_o              (push),
    .cmd_o               (front_cmd)
  );

  // command queue
  ctb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (back_cmd)
  );

  // frame store side
  ctb_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (back_cmd),
    .pop_o        (pop),
    .sweep_busy_o (sweep_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .in_bounds_o  (in_bounds_o),
    .written_o    (written_o),
    .read_value_o (read_value_o)
  );

endmodule

[tb/tb_clipped_transparent_blit_top.sv]
// testbench for clipped_transparent_blit_top: random and directed requests checked
// against a shadow frame store; depends on ctb_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_clipped_transparent_blit_top;

  localparam int SCREEN_W = 40;
  localparam int SCREEN_H = 30;
  localparam int FRAME_CELLS = SCREEN_W * SCREEN_H;
  localparam int RANDOM_ITEMS = 1300;
  localparam int QUIET_ITEMS = 150;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 500000;
  // request code with no function, the block answers with an all-zero result
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]        req;
    logic signed [6:0] pos_x;
    logic signed [5:0] pos_y;
    logic [5:0]        cell_x;
    logic [4:0]        cell_y;
    logic [1:0]        value;
    logic              transparent;
  } blit_req_t;

  typedef struct packed {
    logic       in_bounds;
    logic       written;
    logic [1:0] read_value;
  } blit_result_t;

  // shadow frame store and queue of expected results
  class frame_scoreboard;
    bit [1:0]     shadow_frame [FRAME_CELLS];
    blit_result_t expected_results [$];
    int           errors;

    function new();
      errors = 0;
      foreach (shadow_frame[i]) shadow_frame[i] = 2'd0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // update the shadow store for one accepted request beat
    function void note_request(blit_req_t r);
      blit_result_t res;
      int tx, ty, idx;
      bit hit;
      res = '0;
      tx = int'(r.pos_x) + int'(r.cell_x);
      ty = int'(r.pos_y) + int'(r.cell_y);
      hit = tx >= 0 && ty >= 0 && tx < SCREEN_W && ty < SCREEN_H;
      idx = hit ? ty * SCREEN_W + tx : 0;
      case (r.req)
        ctb_pkg::REQ_CLEAR: begin
          foreach (shadow_frame[i]) shadow_frame[i] = 2'd0;
        end
        ctb_pkg::REQ_BLIT: begin
          res.in_bounds = hit;
          if (hit && (!r.transparent || r.value != 2'd0)) begin
            shadow_frame[idx] = r.value;
            res.written = 1'b1;
          end
        end
        ctb_pkg::REQ_READ: begin
          res.in_bounds = hit;
          if (hit) res.read_value = shadow_frame[idx];
        end
        default: ;
      endcase
      expected_results.insert(expected_results.size(), res);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(blit_result_t got);
      blit_result_t exp_res;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: expected no result, actual in_bounds=%0d written=%0d read_value=%0d",
                 $time, got.in_bounds, got.written, got.read_value);
        return;
      end
      exp_res = expected_results.pop_front();
      if (got.in_bounds !== exp_res.in_bounds) begin
        errors++;
        $display("%0t: in_bounds expected %0d actual %0d",
                 $time, exp_res.in_bounds, got.in_bounds);
      end
      if (got.written !== exp_res.written) begin
        errors++;
        $display("%0t: written expected %0d actual %0d",
                 $time, exp_res.written, got.written);
      end
      if (got.read_value !== exp_res.read_value) begin
        errors++;
        $display("%0t: read_value expected %0d actual %0d",
                 $time, exp_res.read_value, got.read_value);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        req_type_i;
  logic signed [6:0] pos_x_i;
  logic signed [5:0] pos_y_i;
  logic [5:0]        cell_x_i;
  logic [4:0]        cell_y_i;
  logic [1:0]        cell_value_i;
  logic              blend_transparent_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              in_bounds_o;
  logic              written_o;
  logic [1:0]        read_value_o;

  frame_scoreboard sb;
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int cycle_count = 0;

  clipped_transparent_blit_top #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .cell_x_i           (cell_x_i),
    .cell_y_i           (cell_y_i),
    .cell_value_i       (cell_value_i),
    .blend_transparent_i(blend_transparent_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .in_bounds_o        (in_bounds_o),
    .written_o          (written_o),
    .read_value_o       (read_value_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[clipped_transparent_blit_top] ERROR");
      $finish;
    end
  end

  // watch both channels: note the request beat first, then check the result beat
  always @(posedge clk_i) begin : watch
    blit_req_t    r;
    blit_result_t q;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        r.req = req_type_i;
        r.pos_x = pos_x_i;
        r.pos_y = pos_y_i;
        r.cell_x = cell_x_i;
        r.cell_y = cell_y_i;
        r.value = cell_value_i;
        r.transparent = blend_transparent_i;
        sb.note_request(r);
      end
      if (out_valid_o && !out_stall_i) begin
        q.in_bounds = in_bounds_o;
        q.written = written_o;
        q.read_value = read_value_o;
        sb.check_result(q);
      end
    end
  end

  // result side back-pressure: random bursts, one long hold on request
  initial begin : receiver
    bit stall_val;
    int len;
    out_stall_i = 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_val = 1'b1;
        len = LONG_HOLD_CYCLES;
      end else if (quiet) begin
        stall_val = 1'b0;
        len = 1;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_val = 1'b1;
        len = $urandom_range(1, 19);
      end else begin
        stall_val = 1'b0;
        len = $urandom_range(1, 40);
      end
      @(negedge clk_i);
      out_stall_i <= stall_val;
      repeat (len - 1) @(negedge clk_i);
    end
  end

  function automatic blit_req_t make_req(logic [1:0] req, int px, int py, int cx, int cy,
                                         int v, bit t);
    blit_req_t r;
    r.req = req;
    r.pos_x = 7'(px);
    r.pos_y = 6'(py);
    r.cell_x = 6'(cx);
    r.cell_y = 5'(cy);
    r.value = 2'(v);
    r.transparent = t;
    return r;
  endfunction

  // mostly well-formed composites and reads near the screen, some noise
  function automatic blit_req_t random_request();
    blit_req_t r;
    int pick, tx, ty;
    logic [31:0] raw;
    pick = $urandom_range(0, 99);
    raw = $urandom;
    r = make_req(ctb_pkg::REQ_BLIT, int'(raw[6:0]), int'(raw[12:7]), int'(raw[18:13]),
                 int'(raw[23:19]), int'(raw[25:24]), raw[26]);
    if (pick < 2) begin
      r.req = ctb_pkg::REQ_CLEAR;
    end else if (pick < 4) begin
      r.req = REQ_UNUSED;
    end else if (pick < 14) begin
      r.req = raw[27] ? ctb_pkg::REQ_READ : ctb_pkg::REQ_BLIT;
    end else begin
      r.req = (pick < 50) ? ctb_pkg::REQ_READ : ctb_pkg::REQ_BLIT;
      // half the targets land in a small corner so reads find written cells
      if ($urandom_range(0, 1) == 1) begin
        tx = $urandom_range(0, 7);
        ty = $urandom_range(0, 5);
      end else begin
        tx = $urandom_range(0, 45) - 1;
        ty = $urandom_range(0, 32) - 1;
      end
      if (r.req == ctb_pkg::REQ_READ && tx >= 0 && ty >= 0 && $urandom_range(0, 3) != 0) begin
        r.pos_x = 7'd0;
        r.pos_y = 6'd0;
        r.cell_x = 6'(tx);
        r.cell_y = 5'(ty);
      end else begin
        r.pos_x = 7'(tx - int'(r.cell_x));
        r.pos_y = 6'(ty - int'(r.cell_y));
      end
    end
    return r;
  endfunction

  // offer one request beat and wait until it is taken
  task automatic send_request(blit_req_t r);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= r.req;
    pos_x_i <= r.pos_x;
    pos_y_i <= r.pos_y;
    cell_x_i <= r.cell_x;
    cell_y_i <= r.cell_y;
    cell_value_i <= r.value;
    blend_transparent_i <= r.transparent;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_input(int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    bit busy_mode;
    int no_gap_left;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = 2'd0;
    pos_x_i = 7'd0;
    pos_y_i = 6'd0;
    cell_x_i = 6'd0;
    cell_y_i = 5'd0;
    cell_value_i = 2'd0;
    blend_transparent_i = 1'b0;
    busy_mode = 1'b0;
    no_gap_left = 0;
    sb = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: corners, every clip edge, blend modes, reads, unused code, clear
    send_request(make_req(ctb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0));
    send_request(make_req(ctb_pkg::REQ_BLIT, 0, 0, 0, 0, 1, 0));
    send_request(make_req(ctb_pkg::REQ_BLIT, -1, -2, 40, 31, 3, 0));
    send_request(make_req(ctb_pkg::REQ_BLIT, 63, 0, 63, 0, 2, 0));
    send_request(make_req(ctb_pkg::REQ_BLIT, -64, 0, 63, 0, 2, 0));
    send_request(make_req(ctb_pkg::REQ_BLIT, 0, 0, 0, 30, 1, 0));
    send_request(make_req(ctb_pkg::REQ_BLIT, 0, -32, 0, 31, 1, 1));
    send_request(make_req(ctb_pkg::REQ_BLIT, 0, 31, 0, 0, 3, 0));
    send_request(make_req(ctb_pkg::REQ_BLIT, 0, 0, 0, 0, 0, 1));
    send_request(make_req(ctb_pkg::REQ_BLIT, 0, 0, 5, 5, 2, 1));
    send_request(make_req(ctb_pkg::REQ_READ, 0, 0, 39, 29, 0, 0));
    send_request(make_req(ctb_pkg::REQ_BLIT, 0, 0, 39, 29, 0, 0));
    send_request(make_req(ctb_pkg::REQ_READ, 0, 0, 0, 0, 0, 0));
    send_request(make_req(ctb_pkg::REQ_READ, 0, 0, 39, 29, 0, 0));
    send_request(make_req(ctb_pkg::REQ_READ, 3, -1, 2, 6, 0, 0));
    send_request(make_req(ctb_pkg::REQ_READ, 0, 0, 63, 31, 0, 0));
    send_request(make_req(ctb_pkg::REQ_READ, -64, -32, 0, 0, 0, 0));
    send_request(make_req(REQ_UNUSED, -1, -1, 63, 31, 3, 1));
    send_request(make_req(ctb_pkg::REQ_BLIT, -20, 15, 40, 0, 3, 1));
    send_request(make_req(ctb_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    send_request(make_req(ctb_pkg::REQ_READ, 0, 0, 5, 5, 0, 0));
    send_request(make_req(ctb_pkg::REQ_READ, 0, 0, 20, 15, 0, 0));
    wait_all_results();

    // random part
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) busy_mode = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      // fill the block while the result side holds off
      if (i == 400) begin
        long_hold_req = 1'b1;
        no_gap_left = 100;
      end
      if (i == 800) wait_all_results();
      if (!quiet && !busy_mode && no_gap_left == 0 && $urandom_range(0, 4) == 0)
        idle_input($urandom_range(1, 19));
      if (no_gap_left > 0) no_gap_left--;
      send_request(random_request());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain and report
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("[clipped_transparent_blit_top] OK");
    else
      $display("[clipped_transparent_blit_top] ERROR");
    $finish;
  end

endmodule
